// ===== hw/rtl/dsed_pkg.sv =====
// ----------------------------------------------------------------------------
// dsed_pkg
// Shared types and constants of the escape-stuffed frame decoder.
// ----------------------------------------------------------------------------
package dsed_pkg;

  localparam int unsigned MAX_BYTES_DEF = 32;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned COUNT_OUT_W   = 6;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CODE_W-1:0] ESCAPE_RST = 8'h10;
  localparam logic [CODE_W-1:0] START_RST  = 8'h02;
  localparam logic [CODE_W-1:0] END_RST    = 8'h03;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESCAPE = 2'd0,
    CFG_START  = 2'd1,
    CFG_END    = 2'd2
  } dsed_cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_DATA    = 3'd2,
    EV_END     = 3'd3,
    EV_DROP    = 3'd4,
    EV_ABANDON = 3'd5
  } dsed_event_e;

  typedef struct packed {
    logic [CODE_W-1:0] escape_code;
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] end_code;
  } dsed_codes_t;

  typedef struct packed {
    dsed_event_e            ev;
    logic [CODE_W-1:0]      data;
    logic [COUNT_OUT_W-1:0] count;
  } dsed_result_t;

endpackage

// ===== hw/rtl/dle_stx_etx_deframer_core.sv =====
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer_core
// Escape-stuffed frame decoder: one received byte in, one framing event out.
// ----------------------------------------------------------------------------
// Each received byte item gives exactly one result item: an event code
// (nothing, frame start, data byte, frame end, byte dropped, frame abandoned),
// the decoded data byte and the payload count of the open frame. The byte
// passes an input register, is decided by the combinational framing state
// logic and lands in a result register; a new byte is taken every cycle as
// long as results are taken. The user must write the escape, start and end
// codes through the register port only while no item is in flight; the block
// itself does not enforce it. The codes reset to DLE, STX and ETX.
module dle_stx_etx_deframer_core #(
  parameter int unsigned MaxBytes = dsed_pkg::MAX_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dsed_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dsed_pkg::CODE_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dsed_pkg::CODE_W-1:0]      rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       event_res_o,
  output logic [dsed_pkg::CODE_W-1:0]      data_byte_o,
  output logic [dsed_pkg::COUNT_OUT_W-1:0] byte_count_o
);
  import dsed_pkg::*;

  dsed_codes_t       codes_q;
  logic              byte_valid;
  logic [CODE_W-1:0] byte_q;
  logic              advance;
  logic              out_free;
  dsed_result_t      res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.escape_code <= ESCAPE_RST;
      codes_q.start_code  <= START_RST;
      codes_q.end_code    <= END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ESCAPE: codes_q.escape_code <= cfg_data_i;
        CFG_START:  codes_q.start_code  <= cfg_data_i;
        CFG_END:    codes_q.end_code    <= cfg_data_i;
        default:    codes_q             <= codes_q;
      endcase
    end
  end

  assign advance = byte_valid && out_free;

  dsed_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .valid_o    (byte_valid),
    .take_i     (advance),
    .byte_o     (byte_q)
  );

  dsed_fsm #(
    .MaxBytes (MaxBytes)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (byte_q),
    .codes_i   (codes_q),
    .res_o     (res_d)
  );

  dsed_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .free_o      (out_free),
    .res_i       (res_d),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign event_res_o  = res_q.ev;
  assign data_byte_o  = res_q.data;
  assign byte_count_o = res_q.count;

endmodule

// ===== hw/rtl/dsed_in_reg.sv =====
// ----------------------------------------------------------------------------
// dsed_in_reg
// Input register: captures one received byte and holds it until decoded.
// ----------------------------------------------------------------------------
module dsed_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dsed_pkg::CODE_W-1:0] rx_byte_i,
  output logic                       valid_o,
  input  logic                       take_i,
  output logic [dsed_pkg::CODE_W-1:0] byte_o
);
  import dsed_pkg::*;

  logic              valid_q, valid_d;
  logic [CODE_W-1:0] byte_q;
  logic              load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/dsed_fsm.sv =====
// ----------------------------------------------------------------------------
// dsed_fsm
// Framing state and per-byte decision: hunting / in-frame, pending escape
// and payload count, one event per byte.
// ----------------------------------------------------------------------------
module dsed_fsm #(
  parameter int unsigned MaxBytes = dsed_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [dsed_pkg::CODE_W-1:0] byte_i,
  input  dsed_pkg::dsed_codes_t       codes_i,
  output dsed_pkg::dsed_result_t      res_o
);
  import dsed_pkg::*;

  localparam int unsigned CntW = $clog2(MaxBytes + 2);
  localparam logic [CntW-1:0] CntMax  = CntW'(MaxBytes);
  localparam logic [CntW-1:0] CntOver = CntW'(MaxBytes + 1);

  logic              in_frame_q, in_frame_d;
  logic              esc_q, esc_d;
  logic [CntW-1:0]   count_q, count_d;
  dsed_event_e       ev;
  logic [CODE_W-1:0] data;
  logic [CntW+COUNT_OUT_W-1:0] cnt_ext;
  logic              is_esc, is_start, is_end, room;

  assign is_esc   = (byte_i == codes_i.escape_code);
  assign is_start = (byte_i == codes_i.start_code);
  assign is_end   = (byte_i == codes_i.end_code);
  assign room     = (count_q <= CntMax);

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = 1'b0;
    count_d    = count_q;
    ev         = EV_NONE;
    data       = '0;
    if (!esc_q && is_esc) begin
      esc_d = 1'b1;
    end else if (esc_q && is_start) begin
      in_frame_d = 1'b1;
      count_d    = '0;
      ev         = EV_START;
    end else if (!in_frame_q) begin
      ev = EV_NONE;
    end else if (esc_q && is_end) begin
      in_frame_d = 1'b0;
      ev         = EV_END;
    end else if (room) begin
      // plain byte, stuffed escape or escape + other byte
      count_d = count_q + 1'b1;
      data    = byte_i;
      ev      = EV_DATA;
    end else if (esc_q && is_esc) begin
      count_d    = '0;
      in_frame_d = 1'b0;
      ev         = EV_ABANDON;
    end else begin
      ev = EV_DROP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      count_q    <= '0;
    end else if (advance_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      count_q    <= count_d;
    end
  end

  assign cnt_ext     = {{COUNT_OUT_W{1'b0}}, count_d};
  assign res_o.ev    = ev;
  assign res_o.data  = data;
  assign res_o.count = cnt_ext[COUNT_OUT_W-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} <= {1'b0, CntOver}))
    else $error("frame count beyond limit");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && ev == EV_START) |=> (count_q == '0 && in_frame_q && !esc_q))
    else $error("frame start did not clear count");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && (ev == EV_DROP || ev == EV_ABANDON)) |-> (count_q == CntOver))
    else $error("byte dropped while frame had room");

  a_abandon_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && (ev == EV_ABANDON || ev == EV_END)) |=> !in_frame_q)
    else $error("still in frame after end or abandon");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev != EV_DATA) |-> (data == '0))
    else $error("data byte set on non-data event");

endmodule

// ===== hw/rtl/dsed_out_reg.sv =====
// ----------------------------------------------------------------------------
// dsed_out_reg
// Result register: holds one decoded event until the consumer takes it.
// ----------------------------------------------------------------------------
module dsed_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  output logic                   free_o,
  input  dsed_pkg::dsed_result_t res_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dsed_pkg::dsed_result_t res_o
);
  import dsed_pkg::*;

  logic         valid_q, valid_d;
  dsed_result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
